@@ rtl/lpbm_pkg.sv @@
// shared constants, codes and controller/datapath types of the byte mailbox
package lpbm_pkg;

	// ring geometry
	localparam int BUF_SIZE = 64;
	localparam int PTR_W    = $clog2(BUF_SIZE);
	localparam int SUM_W    = 9;
	localparam logic [7:0] LEN_MAX = 8'(BUF_SIZE - 5);

	// request function codes
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_FULL   = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_BADLEN = 3'd3,
		ST_ROOM   = 3'd4
	} status_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_HDR,
		S_EVAL,
		S_PAY
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    rd_load;
		logic    rd_adv;
		logic    hdr_capture;
		logic    do_push;
		logic    flush;
		logic    commit_zero;
		logic    commit_end;
		logic    emit;
		logic    emit_byte;
		logic    emit_len;
		logic    emit_last;
		status_t emit_status;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic slot_free;
		logic ring_empty;
		logic ring_full;
		logic hdr_done;
		logic len_bad;
		logic len_room;
		logic len_zero;
		logic pay_last;
	} dp_stat_t;

	// next pointer with wrap at the ring size
	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(BUF_SIZE - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

@@ rtl/lpbm_req_if.sv @@
// request channel interface of the byte mailbox
interface lpbm_req_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] data_byte;
	logic [7:0] room;

	modport source (output valid, output func, output data_byte, output room, input ready);
	modport sink (input valid, input func, input data_byte, input room, output ready);
endinterface

@@ rtl/lpbm_rsp_if.sv @@
// result channel interface of the byte mailbox
interface lpbm_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [7:0] body_len;
	logic       last;
	logic       not_empty;

	modport source (output valid, output status, output out_byte, output byte_valid,
		output body_len, output last, output not_empty, input ready);
	modport sink (input valid, input status, input out_byte, input byte_valid,
		input body_len, input last, input not_empty, output ready);
endinterface

@@ rtl/lpbm_ctrl.sv @@
// controller state machine of the byte mailbox
module lpbm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_func,
	output logic               req_ready,
	input  lpbm_pkg::dp_stat_t stat,
	output lpbm_pkg::cmd_t     cmd
);

	lpbm_pkg::state_t state_q;
	lpbm_pkg::state_t state_d;
	logic             accept;

	assign accept = (state_q == lpbm_pkg::S_IDLE) && stat.slot_free && req_valid;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpbm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lpbm_pkg::S_IDLE: begin
				if (accept && req_func == lpbm_pkg::FUNC_POP && !stat.ring_empty) begin
					state_d = lpbm_pkg::S_HDR;
				end
			end
			lpbm_pkg::S_HDR: begin
				if (stat.hdr_done) begin
					state_d = lpbm_pkg::S_EVAL;
				end
			end
			lpbm_pkg::S_EVAL: begin
				if (stat.len_bad || stat.len_room || stat.len_zero) begin
					if (stat.slot_free) begin
						state_d = lpbm_pkg::S_IDLE;
					end
				end else begin
					state_d = lpbm_pkg::S_PAY;
				end
			end
			lpbm_pkg::S_PAY: begin
				if (stat.slot_free && stat.pay_last) begin
					state_d = lpbm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lpbm_pkg::S_IDLE;
			end
		endcase
	end

	// command outputs
	always_comb begin
		cmd             = '0;
		cmd.emit_status = lpbm_pkg::ST_OK;
		req_ready       = 1'b0;
		case (state_q)
			lpbm_pkg::S_IDLE: begin
				req_ready = stat.slot_free;
				if (accept) begin
					if (req_func == lpbm_pkg::FUNC_PUSH) begin
						cmd.emit        = 1'b1;
						cmd.emit_last   = 1'b1;
						cmd.do_push     = !stat.ring_full;
						cmd.emit_status = stat.ring_full ? lpbm_pkg::ST_FULL : lpbm_pkg::ST_OK;
					end else if (stat.ring_empty) begin
						cmd.emit        = 1'b1;
						cmd.emit_last   = 1'b1;
						cmd.emit_status = lpbm_pkg::ST_EMPTY;
					end else begin
						cmd.rd_load = 1'b1;
					end
				end
			end
			lpbm_pkg::S_HDR: begin
				cmd.hdr_capture = 1'b1;
				cmd.rd_adv      = 1'b1;
			end
			lpbm_pkg::S_EVAL: begin
				if (stat.len_bad) begin
					cmd.emit        = stat.slot_free;
					cmd.flush       = stat.slot_free;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = lpbm_pkg::ST_BADLEN;
				end else if (stat.len_room) begin
					cmd.emit        = stat.slot_free;
					cmd.emit_len    = 1'b1;
					cmd.emit_last   = 1'b1;
					cmd.emit_status = lpbm_pkg::ST_ROOM;
				end else if (stat.len_zero) begin
					cmd.emit        = stat.slot_free;
					cmd.commit_zero = stat.slot_free;
					cmd.emit_last   = 1'b1;
				end else begin
					cmd.commit_end = 1'b1;
				end
			end
			lpbm_pkg::S_PAY: begin
				cmd.emit      = stat.slot_free;
				cmd.rd_adv    = stat.slot_free;
				cmd.emit_byte = 1'b1;
				cmd.emit_len  = 1'b1;
				cmd.emit_last = stat.pay_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

@@ rtl/lpbm_dp.sv @@
// datapath of the byte mailbox: ring memory, pointers, header decode, result register
module lpbm_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         data_byte,
	input  logic [7:0]         room,
	input  lpbm_pkg::cmd_t     cmd,
	output lpbm_pkg::dp_stat_t stat,
	lpbm_rsp_if.source         rsp
);

	logic [7:0]                 mem_q [lpbm_pkg::BUF_SIZE];
	logic [7:0]                 rd_data_q;
	logic [lpbm_pkg::PTR_W-1:0] wp_q;
	logic [lpbm_pkg::PTR_W-1:0] rp_q;
	logic [lpbm_pkg::PTR_W-1:0] p_q;
	logic [lpbm_pkg::PTR_W-1:0] wp_d;
	logic [lpbm_pkg::PTR_W-1:0] rp_d;
	logic [lpbm_pkg::PTR_W-1:0] rd_addr;
	logic [lpbm_pkg::PTR_W-1:0] end_ptr;
	logic [lpbm_pkg::SUM_W-1:0] end_sum;
	logic [1:0]                 hdr_cnt_q;
	logic [7:0]                 len_q;
	logic                       hi_nz_q;
	logic [7:0]                 room_q;
	logic [7:0]                 rem_q;
	logic                       out_valid_q;

	// status to controller
	assign stat.slot_free  = !out_valid_q || rsp.ready;
	assign stat.ring_empty = (rp_q == wp_q);
	assign stat.ring_full  = (lpbm_pkg::wrap_next(wp_q) == rp_q);
	assign stat.hdr_done   = (hdr_cnt_q == 2'd3);
	assign stat.len_bad    = hi_nz_q || (len_q > lpbm_pkg::LEN_MAX);
	assign stat.len_room   = (len_q > room_q);
	assign stat.len_zero   = (len_q == 8'd0);
	assign stat.pay_last   = (rem_q == 8'd1);

	// read address: reload from read pointer, step, or hold
	always_comb begin
		if (cmd.rd_load) begin
			rd_addr = rp_q;
		end else if (cmd.rd_adv) begin
			rd_addr = lpbm_pkg::wrap_next(p_q);
		end else begin
			rd_addr = p_q;
		end
	end

	// end of payload, length already known to be below the ring size
	assign end_sum = lpbm_pkg::SUM_W'(p_q) + lpbm_pkg::SUM_W'(len_q);
	always_comb begin
		if (end_sum >= lpbm_pkg::SUM_W'(lpbm_pkg::BUF_SIZE)) begin
			end_ptr = lpbm_pkg::PTR_W'(end_sum - lpbm_pkg::SUM_W'(lpbm_pkg::BUF_SIZE));
		end else begin
			end_ptr = lpbm_pkg::PTR_W'(end_sum);
		end
	end

	// next pointer values
	always_comb begin
		wp_d = cmd.do_push ? lpbm_pkg::wrap_next(wp_q) : wp_q;
		rp_d = rp_q;
		if (cmd.flush) begin
			rp_d = wp_q;
		end else if (cmd.commit_zero) begin
			rp_d = p_q;
		end else if (cmd.commit_end) begin
			rp_d = end_ptr;
		end
	end

	// ring memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.do_push) begin
			mem_q[wp_q] <= data_byte;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// pointers and control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			rp_q        <= '0;
			hdr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			wp_q <= wp_d;
			rp_q <= rp_d;
			if (cmd.rd_load) begin
				hdr_cnt_q <= '0;
			end else if (cmd.hdr_capture) begin
				hdr_cnt_q <= hdr_cnt_q + 2'd1;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// header decode, room and payload count
	always_ff @(posedge clk) begin
		p_q <= rd_addr;
		if (cmd.rd_load) begin
			room_q <= room;
		end
		if (cmd.hdr_capture) begin
			if (hdr_cnt_q == 2'd0) begin
				len_q   <= rd_data_q;
				hi_nz_q <= 1'b0;
			end else begin
				hi_nz_q <= hi_nz_q || (rd_data_q != 8'd0);
			end
		end
		if (cmd.commit_end) begin
			rem_q <= len_q;
		end else if (cmd.emit && cmd.emit_byte) begin
			rem_q <= rem_q - 8'd1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp.status     <= cmd.emit_status;
			rsp.out_byte   <= cmd.emit_byte ? rd_data_q : 8'd0;
			rsp.byte_valid <= cmd.emit_byte;
			rsp.body_len   <= cmd.emit_len ? len_q : 8'd0;
			rsp.last       <= cmd.emit_last;
			rsp.not_empty  <= (rp_d != wp_d);
		end
	end

	assign rsp.valid = out_valid_q;

	// a push never lands on a full ring
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_push |-> !stat.ring_full)
		else $error("push written into a full ring");

	// a flush leaves the ring empty
	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> (rp_q == wp_q))
		else $error("ring not empty after flush");

	// payload bytes are emitted only while some remain
	a_pay_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_byte) |-> (rem_q != 8'd0))
		else $error("payload byte emitted past the message length");

	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rp_q <= lpbm_pkg::PTR_W'(lpbm_pkg::BUF_SIZE - 1))
		&& (wp_q <= lpbm_pkg::PTR_W'(lpbm_pkg::BUF_SIZE - 1)))
		else $error("ring pointer out of range");

endmodule

@@ rtl/length_prefixed_byte_mailbox_top.sv @@
// top level of the length-prefixed byte mailbox
// Byte ring mailbox with one slot always kept free.
// req channel: func selects push (store data_byte) or pop (read one message,
// room is the receiver's capacity). rsp channel: one result per push, one per
// refused, empty or zero-length pop, and one result per payload byte on a
// pop with payload. Push: the result appears in the output register on the
// next cycle; with rsp ready, one push is taken every cycle.
// Pop: the little-endian length header is read through the single
// registered memory read port and then evaluated, then one payload byte
// leaves per cycle while rsp is ready; req is not ready again until the pop
// has issued its last result, and an empty-ring pop ends when accepted.
// All results sit in one output register: a new request is taken while a
// finished result waits, as long as that register is free or being taken.
// A stalled rsp holds the pending result unchanged and stops further results; header reads still go on.
// Reset clears both pointers (ring empty) and the output valid flag; the ring
// memory and the output register contents are not cleared.
module length_prefixed_byte_mailbox_top (
	input  logic       clk,
	input  logic       arst_n,
	lpbm_req_if.sink   req,
	lpbm_rsp_if.source rsp
);

	lpbm_pkg::cmd_t     cmd;
	lpbm_pkg::dp_stat_t stat;

	// controller
	lpbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.func),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	lpbm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (req.data_byte),
		.room      (req.room),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule
